// ----- sv/cdq_pkg.sv -----
// Package for the circular deque with key search.
// Holds the sizes, operation and status codes, and the record and control types.
// No dependencies.
package cdq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned FUNC_W = 4;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned POS_W = 5;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    F_PUSH_BACK  = 4'd0,
    F_PUSH_FRONT = 4'd1,
    F_POP_FRONT  = 4'd2,
    F_POP_BACK   = 4'd3,
    F_FIND       = 4'd4,
    F_HOME       = 4'd5,
    F_RIGHT      = 4'd6,
    F_LEFT       = 4'd7,
    F_READ       = 4'd8
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHL,
    CELL_SHR
  } cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_ROTATE
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } rec_t;

  typedef struct packed {
    cell_op_e op;
    logic     feed_new;
  } cell_ctl_t;

  typedef struct packed {
    status_e          status;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] count;
  } rsp_t;

endpackage

// ----- sv/cdq_if.sv -----
// Handshake interfaces for the request and response channels of the deque.
// Depends on cdq_pkg for the field widths.
interface cdq_req_if;
  logic                         valid;
  logic                         ready;
  logic [cdq_pkg::FUNC_W-1:0]   func;
  logic [cdq_pkg::KEY_W-1:0]    entry_key;
  logic [cdq_pkg::PAY_W-1:0]    entry_payload;

  modport source (output valid, func, entry_key, entry_payload, input ready);
  modport sink (input valid, func, entry_key, entry_payload, output ready);
endinterface

interface cdq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cdq_pkg::STAT_W-1:0]   status;
  logic [cdq_pkg::KEY_W-1:0]    out_key;
  logic [cdq_pkg::PAY_W-1:0]    out_payload;
  logic [cdq_pkg::POS_W-1:0]    position;
  logic [cdq_pkg::POS_W-1:0]    count;

  modport source (output valid, status, out_key, out_payload, position, count, input ready);
  modport sink (input valid, status, out_key, out_payload, position, count, output ready);
endinterface

// ----- sv/circular_deque_with_key_search.sv -----
// Push back, pop back, find and cursor operations that are not refused rotate the chain
// for a full turn, and the next item waits until it is over; the others allow one item a
// cycle. Push front, push back, pop front, refused operations and unknown codes answer in
// the cycle after acceptance; pop back, find and cursor operations answer after the turn.
// A result left waiting holds back the next item. Reset (asynchronous, active low) clears
// count, cursor and sequencer at once; record cells are not cleared, with no clearing pass.
//
// Depends on cdq_pkg, cdq_if, cdq_cell and cdq_ctrl.
module circular_deque_with_key_search (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdq_req_if.sink    req_i,
  cdq_rsp_if.source  rsp_o
);

  localparam int unsigned DEPTH = cdq_pkg::DEPTH;

  // The records live in a row of cells, cell 0 always holding the head of the
  // deque and cell k the entry at offset k from the head. Pushing at the front
  // shifts every cell one place to the right; popping from the front shifts
  // them left. Everything that needs an entry deep in the deque rotates the row
  // left for a full turn, so that every entry passes cell 0 in order and the
  // row ends where it started. During that turn a push at the back swaps its
  // new record in for the free slot as it goes past.
  cdq_pkg::rec_t      cell_rec [DEPTH];
  cdq_pkg::rec_t      ins_rec;
  cdq_pkg::rec_t      feedback;
  cdq_pkg::cell_ctl_t cell_ctl;
  cdq_pkg::rsp_t      rsp;
  logic               rsp_valid;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .func_i      (req_i.func),
    .key_i       (req_i.entry_key),
    .payload_i   (req_i.entry_payload),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .head_i      (cell_rec[0]),
    .cell_ctl_o  (cell_ctl),
    .ins_rec_o   (ins_rec)
  );

  // The record that re-enters the far end of the row during a rotation.
  assign feedback = cell_ctl.feed_new ? ins_rec : cell_rec[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cdq_pkg::rec_t left_rec;
    cdq_pkg::rec_t right_rec;

    if (i == 0) begin : g_first
      assign left_rec = ins_rec;
    end else begin : g_mid_left
      assign left_rec = cell_rec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_rec = feedback;
    end else begin : g_mid_right
      assign right_rec = cell_rec[i+1];
    end

    cdq_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .left_i  (left_rec),
      .right_i (right_rec),
      .rec_o   (cell_rec[i])
    );
  end

  // The result register sits in the sequencer. A new item is only taken once
  // the result before it has been accepted, or is being accepted in that cycle.
  assign rsp_o.valid       = rsp_valid;
  assign rsp_o.status      = rsp.status;
  assign rsp_o.out_key     = rsp.out_key;
  assign rsp_o.out_payload = rsp.out_payload;
  assign rsp_o.position    = rsp.position;
  assign rsp_o.count       = rsp.count;

endmodule

// ----- sv/cdq_cell.sv -----
// One storage cell of the deque chain: a record register that holds, or loads
// from its left or right neighbour. Depends on cdq_pkg.
module cdq_cell (
  input  logic               clk_i,
  input  cdq_pkg::cell_ctl_t ctl_i,
  input  cdq_pkg::rec_t      left_i,
  input  cdq_pkg::rec_t      right_i,
  output cdq_pkg::rec_t      rec_o
);

  cdq_pkg::rec_t rec_q, rec_d;

  always_comb begin
    unique case (ctl_i.op)
      cdq_pkg::CELL_SHL: rec_d = right_i;
      cdq_pkg::CELL_SHR: rec_d = left_i;
      default:           rec_d = rec_q;
    endcase
  end

  // Record contents carry no reset; only live entries are ever reported.
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

// ----- sv/cdq_ctrl.sv -----
// Sequencer of the deque: count, cursor, rotation step and the result register.
// Drives the cell chain and watches the head cell. Depends on cdq_pkg.
module cdq_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  logic [cdq_pkg::FUNC_W-1:0]   func_i,
  input  logic [cdq_pkg::KEY_W-1:0]    key_i,
  input  logic [cdq_pkg::PAY_W-1:0]    payload_i,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  output cdq_pkg::rsp_t                rsp_o,
  input  cdq_pkg::rec_t                head_i,
  output cdq_pkg::cell_ctl_t           cell_ctl_o,
  output cdq_pkg::rec_t                ins_rec_o
);

  localparam int unsigned IDX_W = cdq_pkg::IDX_W;
  localparam int unsigned CNT_W = cdq_pkg::CNT_W;
  localparam int unsigned POS_W = cdq_pkg::POS_W;

  cdq_pkg::state_e               state_q, state_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [IDX_W-1:0]              cursor_q, cursor_d;
  logic [IDX_W-1:0]              step_q, step_d;
  logic [IDX_W-1:0]              tgt_q, tgt_d;
  cdq_pkg::func_e                func_q, func_d;
  logic [cdq_pkg::KEY_W-1:0]     key_q, key_d;
  logic [cdq_pkg::PAY_W-1:0]     pay_q, pay_d;
  cdq_pkg::rec_t                 cap_q, cap_d;
  logic [CNT_W-1:0]              cap_pos_q, cap_pos_d;
  logic                          found_q, found_d;
  logic                          rsp_valid_q, rsp_valid_d;
  cdq_pkg::rsp_t                 rsp_q, rsp_d;

  cdq_pkg::func_e                func_in;
  logic                          accept;
  logic                          full;
  logic                          empty;
  logic                          hit;
  logic                          last_step;
  logic [IDX_W-1:0]              new_cursor;
  logic [CNT_W-1:0]              step_pos;

  assign func_in   = cdq_pkg::func_e'(func_i);
  assign full      = (count_q == CNT_W'(cdq_pkg::DEPTH));
  assign empty     = (count_q == '0);
  assign last_step = (step_q == IDX_W'(cdq_pkg::DEPTH - 1));
  assign step_pos  = CNT_W'(step_q) + CNT_W'(1);

  assign req_ready_o = (state_q == cdq_pkg::S_IDLE) && (!rsp_valid_q || rsp_ready_i);
  assign accept      = req_valid_i && req_ready_o;

  // A find hits on the first live entry whose key matches; the other rotating
  // operations hit on their target offset.
  always_comb begin
    if (func_q == cdq_pkg::F_FIND) begin
      hit = !found_q && (CNT_W'(step_q) < count_q) && (head_i.key == key_q);
    end else begin
      hit = (step_q == tgt_q);
    end
  end

  always_comb begin
    unique case (func_in)
      cdq_pkg::F_HOME:  new_cursor = '0;
      cdq_pkg::F_RIGHT: begin
        new_cursor = (CNT_W'(cursor_q) + CNT_W'(1) == count_q) ? '0 : cursor_q + IDX_W'(1);
      end
      cdq_pkg::F_LEFT: begin
        new_cursor = (cursor_q == '0) ? IDX_W'(count_q - CNT_W'(1)) : cursor_q - IDX_W'(1);
      end
      default:          new_cursor = (CNT_W'(cursor_q) >= count_q) ? '0 : cursor_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    step_d      = step_q;
    tgt_d       = tgt_q;
    func_d      = func_q;
    key_d       = key_q;
    pay_d       = pay_q;
    cap_d       = cap_q;
    cap_pos_d   = cap_pos_q;
    found_d     = found_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rsp_d       = rsp_q;
    cell_ctl_o  = '{op: cdq_pkg::CELL_HOLD, feed_new: 1'b0};
    ins_rec_o   = (state_q == cdq_pkg::S_IDLE)
                ? cdq_pkg::rec_t'{key: key_i, payload: payload_i}
                : cdq_pkg::rec_t'{key: key_q, payload: pay_q};

    unique case (state_q)
      cdq_pkg::S_IDLE: begin
        if (accept) begin
          func_d  = func_in;
          key_d   = key_i;
          pay_d   = payload_i;
          step_d  = '0;
          found_d = 1'b0;
          rsp_valid_d = 1'b1;
          rsp_d   = '{status: cdq_pkg::ST_OK, out_key: '0, out_payload: '0,
                      position: '0, count: POS_W'(count_q)};
          unique case (func_in)
            cdq_pkg::F_PUSH_BACK, cdq_pkg::F_PUSH_FRONT: begin
              cursor_d = '0;
              if (full) begin
                rsp_d.status = cdq_pkg::ST_FULL;
              end else begin
                count_d           = count_q + CNT_W'(1);
                rsp_d.out_key     = key_i;
                rsp_d.out_payload = payload_i;
                rsp_d.count       = POS_W'(count_q + CNT_W'(1));
                if (func_in == cdq_pkg::F_PUSH_FRONT) begin
                  rsp_d.position = POS_W'(1);
                  cell_ctl_o.op  = cdq_pkg::CELL_SHR;
                end else begin
                  rsp_d.position = POS_W'(count_q + CNT_W'(1));
                  tgt_d          = IDX_W'(count_q);
                  state_d        = cdq_pkg::S_ROTATE;
                end
              end
            end
            cdq_pkg::F_POP_FRONT, cdq_pkg::F_POP_BACK: begin
              cursor_d = '0;
              if (empty) begin
                rsp_d.status = cdq_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
                if (func_in == cdq_pkg::F_POP_FRONT) begin
                  rsp_d.out_key     = head_i.key;
                  rsp_d.out_payload = head_i.payload;
                  rsp_d.position    = POS_W'(1);
                  rsp_d.count       = POS_W'(count_q - CNT_W'(1));
                  cell_ctl_o.op     = cdq_pkg::CELL_SHL;
                end else begin
                  tgt_d       = IDX_W'(count_q - CNT_W'(1));
                  state_d     = cdq_pkg::S_ROTATE;
                  rsp_valid_d = 1'b0;
                end
              end
            end
            cdq_pkg::F_FIND, cdq_pkg::F_HOME, cdq_pkg::F_RIGHT, cdq_pkg::F_LEFT,
            cdq_pkg::F_READ: begin
              if (empty) begin
                rsp_d.status = cdq_pkg::ST_EMPTY;
              end else begin
                if (func_in != cdq_pkg::F_FIND) begin
                  cursor_d = new_cursor;
                  tgt_d    = new_cursor;
                end
                state_d     = cdq_pkg::S_ROTATE;
                rsp_valid_d = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      cdq_pkg::S_ROTATE: begin
        cell_ctl_o.op       = cdq_pkg::CELL_SHL;
        cell_ctl_o.feed_new = (func_q == cdq_pkg::F_PUSH_BACK) && (step_q == tgt_q);
        step_d              = step_q + IDX_W'(1);
        if (hit && (func_q != cdq_pkg::F_PUSH_BACK)) begin
          cap_d     = head_i;
          cap_pos_d = step_pos;
          found_d   = 1'b1;
        end
        if (last_step) begin
          state_d = cdq_pkg::S_IDLE;
          if (func_q != cdq_pkg::F_PUSH_BACK) begin
            rsp_valid_d = 1'b1;
            rsp_d = '{status: cdq_pkg::ST_NOTFOUND, out_key: '0, out_payload: '0,
                      position: '0, count: POS_W'(count_q)};
            if (hit) begin
              rsp_d.status      = cdq_pkg::ST_OK;
              rsp_d.out_key     = head_i.key;
              rsp_d.out_payload = head_i.payload;
              rsp_d.position    = POS_W'(step_pos);
            end else if (found_q) begin
              rsp_d.status      = cdq_pkg::ST_OK;
              rsp_d.out_key     = cap_q.key;
              rsp_d.out_payload = cap_q.payload;
              rsp_d.position    = POS_W'(cap_pos_q);
            end
          end
        end
      end

      default: begin
        state_d = cdq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdq_pkg::S_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      step_q      <= '0;
      tgt_q       <= '0;
      func_q      <= cdq_pkg::F_PUSH_BACK;
      found_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      step_q      <= step_d;
      tgt_q       <= tgt_d;
      func_q      <= func_d;
      found_q     <= found_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    pay_q     <= pay_d;
    cap_q     <= cap_d;
    cap_pos_q <= cap_pos_d;
    rsp_q     <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ----- sv/cdq_checker.sv -----
// Port-level checks for the circular deque, attached to the top level by bind.
// Depends on cdq_pkg and circular_deque_with_key_search.
module cdq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [cdq_pkg::STAT_W-1:0]   status_i,
  input logic [cdq_pkg::POS_W-1:0]    position_i,
  input logic [cdq_pkg::POS_W-1:0]    count_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) && $stable(count_i))
    else $error("result changed while stalled");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> count_i <= cdq_pkg::POS_W'(cdq_pkg::DEPTH))
    else $error("count beyond depth");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == cdq_pkg::ST_FULL |->
      count_i == cdq_pkg::POS_W'(cdq_pkg::DEPTH) && position_i == '0)
    else $error("full reported with room left");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == cdq_pkg::ST_EMPTY |-> count_i == '0 && position_i == '0)
    else $error("empty reported with entries held");

  a_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == cdq_pkg::ST_OK |->
      position_i <= count_i + cdq_pkg::POS_W'(1))
    else $error("position beyond the held entries");

endmodule

bind circular_deque_with_key_search cdq_checker u_cdq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .position_i  (rsp_o.position),
  .count_i     (rsp_o.count)
);

// ----- dv/circular_deque_with_key_search_tb.sv -----
// Self-checking testbench for circular_deque_with_key_search.
// Drives the request channel, mirrors the deque in a shadow model and checks every answer.
// Depends on cdq_pkg, cdq_if and the RTL of the block.
module circular_deque_with_key_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  // Function codes above F_READ do nothing but still answer.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 4'd9;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 4'd15;

  // Slowest operations hold the block for a full chain turn; the run has a
  // little over a thousand items plus idling on both sides, so this is ample.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned KEY_POOL_N  = 6;

  logic clk_i;
  logic rst_ni;

  cdq_req_if req_if ();
  cdq_rsp_if rsp_if ();

  circular_deque_with_key_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the deque: record storage, head slot, fill level and the
  // browse cursor held as a distance from the head.
  logic [KEY_W-1:0] shadow_keys [DEPTH];
  logic [PAY_W-1:0] shadow_pays [DEPTH];
  int unsigned      shadow_head;
  int unsigned      shadow_held;
  int unsigned      shadow_cursor;

  // Answers that the block owes us, oldest first.
  rsp_t             pending_answers [$];
  int unsigned      answer_mismatches;
  int unsigned      cycle_cnt;

  // Idling controls, shared between the test tasks and the answer sink.
  bit               sender_idle_en;
  bit               rx_idle_en;
  int unsigned      rx_hold_req;

  // Keys are mostly drawn from a small pool so that searches hit and
  // duplicate keys are common enough to test the first-match rule.
  logic [KEY_W-1:0] key_pool [KEY_POOL_N];

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Watchdog: a hung handshake must not leave the run spinning.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("circular_deque_with_key_search_tb: done, errors");
      $finish;
    end
  end

  // Works out the answer to one operation and updates the shadow state, in the
  // same order as the block: pushes and pops send the cursor home first, even
  // when they are refused.
  function automatic rsp_t deque_answer(input logic [FUNC_W-1:0] f,
                                        input logic [KEY_W-1:0]  k,
                                        input logic [PAY_W-1:0]  p);
    rsp_t        ans;
    int unsigned slot;
    int unsigned idx;
    bit          hit;
    ans        = '0;
    ans.status = ST_OK;
    hit        = 1'b0;
    if (f <= F_POP_BACK) shadow_cursor = 0;
    if (f == F_PUSH_BACK || f == F_PUSH_FRONT) begin
      if (shadow_held >= DEPTH) begin
        ans.status = ST_FULL;
      end else begin
        if (f == F_PUSH_BACK) begin
          slot         = (shadow_head + shadow_held) % DEPTH;
          ans.position = POS_W'(shadow_held + 1);
        end else begin
          shadow_head  = (shadow_head + DEPTH - 1) % DEPTH;
          slot         = shadow_head;
          ans.position = POS_W'(1);
        end
        shadow_keys[slot] = k;
        shadow_pays[slot] = p;
        shadow_held++;
        ans.out_key     = k;
        ans.out_payload = p;
      end
    end else if (f > F_READ) begin
      // Unknown codes answer ok with the current count and touch nothing.
    end else if (shadow_held == 0) begin
      ans.status = ST_EMPTY;
    end else begin
      case (f)
        F_POP_FRONT: begin
          ans.out_key     = shadow_keys[shadow_head];
          ans.out_payload = shadow_pays[shadow_head];
          ans.position    = POS_W'(1);
          shadow_head     = (shadow_head + 1) % DEPTH;
          shadow_held--;
          if (shadow_held == 0) shadow_head = 0;
        end
        F_POP_BACK: begin
          slot            = (shadow_head + shadow_held - 1) % DEPTH;
          ans.out_key     = shadow_keys[slot];
          ans.out_payload = shadow_pays[slot];
          ans.position    = POS_W'(shadow_held);
          shadow_held--;
          if (shadow_held == 0) shadow_head = 0;
        end
        F_FIND: begin
          // First match counted from the head wins.
          for (idx = 0; idx < shadow_held && !hit; idx++) begin
            slot = (shadow_head + idx) % DEPTH;
            if (shadow_keys[slot] == k) begin
              hit             = 1'b1;
              ans.out_key     = shadow_keys[slot];
              ans.out_payload = shadow_pays[slot];
              ans.position    = POS_W'(idx + 1);
            end
          end
          if (!hit) ans.status = ST_NOTFOUND;
        end
        default: begin
          // Cursor operations: home goes to the head, right and left wrap round
          // the live records, and read leaves the cursor where it is.
          if (f == F_HOME) begin
            shadow_cursor = 0;
          end else if (f == F_RIGHT) begin
            shadow_cursor = (shadow_cursor + 1) % shadow_held;
          end else if (f == F_LEFT) begin
            shadow_cursor = (shadow_cursor == 0) ? shadow_held - 1 : shadow_cursor - 1;
          end
          if (shadow_cursor >= shadow_held) shadow_cursor = 0;
          slot            = (shadow_head + shadow_cursor) % DEPTH;
          ans.out_key     = shadow_keys[slot];
          ans.out_payload = shadow_pays[slot];
          ans.position    = POS_W'(shadow_cursor + 1);
        end
      endcase
    end
    ans.count = POS_W'(shadow_held);
    return ans;
  endfunction

  // Offers one item, entered and left at a falling edge. Valid is left high
  // on return so that back-to-back items never drop it within one time step.
  task automatic offer_request(input logic [FUNC_W-1:0] f,
                               input logic [KEY_W-1:0]  k,
                               input logic [PAY_W-1:0]  p);
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.func          <= f;
    req_if.entry_key     <= k;
    req_if.entry_payload <= p;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pending_answers.push_back(deque_answer(f, k, p));
    @(negedge clk_i);
  endtask

  // The sender goes quiet until every outstanding answer has come back.
  // At least one falling edge passes, so valid is never raised again in
  // the step where it was lowered.
  task automatic wait_answers_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_answers.size() != 0);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int unsigned pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    return $urandom;
  endfunction

  // Picks an operation; the bias leans the mix towards filling the deque,
  // draining it, or neither, so the count sweeps its whole range.
  function automatic logic [FUNC_W-1:0] pick_func(input int unsigned bias);
    int unsigned roll;
    int unsigned push_pct;
    int unsigned pop_pct;
    case (bias)
      0:       begin push_pct = 55; pop_pct = 15; end
      1:       begin push_pct = 15; pop_pct = 55; end
      default: begin push_pct = 30; pop_pct = 30; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return $urandom_range(0, 1) ? F_PUSH_FRONT : F_PUSH_BACK;
    if (roll < push_pct + pop_pct) return $urandom_range(0, 1) ? F_POP_FRONT : F_POP_BACK;
    roll = $urandom_range(0, 19);
    if (roll < 7)  return F_FIND;
    if (roll < 9)  return F_HOME;
    if (roll < 12) return F_RIGHT;
    if (roll < 15) return F_LEFT;
    if (roll < 19) return F_READ;
    return FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
  endfunction

  // Hand-picked items from reset: every pop, search and cursor operation on an
  // empty deque, the unknown codes, the extreme key and payload values, the only
  // record being popped, a front push wrapping the head below slot zero, search
  // hit and miss, and the cursor wrapping both ways.
  task automatic test_directed();
    offer_request(F_POP_FRONT, '0, '0);
    offer_request(F_POP_BACK, '0, '0);
    offer_request(F_FIND, 32'hFFFF_FFFF, '0);
    offer_request(F_HOME, '0, '0);
    offer_request(F_RIGHT, '0, '0);
    offer_request(F_LEFT, '0, '0);
    offer_request(F_READ, '0, '0);
    offer_request(FUNC_UNUSED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_request(FUNC_UNUSED_HI, '0, '0);
    offer_request(F_PUSH_BACK, '0, '0);
    offer_request(F_POP_FRONT, '0, '0);
    offer_request(F_PUSH_BACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_request(F_PUSH_FRONT, 32'h0000_0001, 32'h0000_0002);
    offer_request(F_PUSH_BACK, 32'h0000_0003, 32'h0000_0004);
    offer_request(F_FIND, 32'hFFFF_FFFF, '0);
    offer_request(F_FIND, 32'h0000_0005, '0);
    offer_request(F_LEFT, '0, '0);
    offer_request(F_RIGHT, '0, '0);
    offer_request(F_RIGHT, '0, '0);
    offer_request(F_READ, '0, '0);
    offer_request(F_HOME, '0, '0);
    offer_request(F_POP_BACK, '0, '0);
    offer_request(F_POP_FRONT, '0, '0);
    offer_request(F_POP_FRONT, '0, '0);
  endtask

  // Fills the deque to capacity, tries both pushes on a full deque, searches
  // for the last record pushed, which went in at the front, then empties
  // it from alternating ends and pops once more when empty.
  task automatic test_fill_to_capacity();
    logic [KEY_W-1:0] tail_key;
    tail_key = '0;
    while (shadow_held < DEPTH) begin
      tail_key = $urandom;
      offer_request(shadow_held[0] ? F_PUSH_FRONT : F_PUSH_BACK, tail_key, $urandom);
    end
    offer_request(F_PUSH_BACK, $urandom, $urandom);
    offer_request(F_PUSH_FRONT, $urandom, $urandom);
    offer_request(F_LEFT, '0, '0);
    offer_request(F_FIND, tail_key, '0);
    while (shadow_held != 0) begin
      offer_request(shadow_held[0] ? F_POP_BACK : F_POP_FRONT, '0, '0);
    end
    offer_request(F_POP_BACK, '0, '0);
  endtask

  // The answer side holds off for a long stretch while the sender keeps
  // offering items without gaps, so the block backs up and stalls its input.
  task automatic test_answer_backpressure();
    int unsigned n;
    sender_idle_en = 1'b0;
    rx_hold_req    = 120;
    for (n = 0; n < 30; n++) begin
      offer_request(pick_func(0), pick_key(80), $urandom);
    end
    wait_answers_drained();
  endtask

  // Long random mix. The bias changes every forty items; with idling on, the
  // sender waits for all answers at times, and the key pool is refreshed rarely.
  task automatic test_random_mix(input int unsigned n_items, input bit with_idle);
    int unsigned      n;
    int unsigned      bias;
    logic [FUNC_W-1:0] f;
    sender_idle_en = with_idle;
    rx_idle_en     = with_idle;
    bias           = 2;
    for (n = 0; n < n_items; n++) begin
      if (n % 40 == 0) bias = $urandom_range(0, 2);
      if ($urandom_range(0, 99) == 0) key_pool[$urandom_range(0, KEY_POOL_N - 1)] = $urandom;
      f = pick_func(bias);
      offer_request(f, pick_key((f == F_FIND) ? 75 : 85), $urandom);
      if (with_idle && n % 250 == 249) wait_answers_drained();
    end
  endtask

  // Answer sink: random stall bursts when idling is on, and a long
  // hold-off counted down here when a test asks for one.
  initial begin : answer_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left   = 0;
    hold_left    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Every accepted answer is compared field by field with the oldest one owed.
  always @(posedge clk_i) begin : answer_check
    rsp_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_answers.size() == 0) begin
        if (answer_mismatches < 10) begin
          $display("%0t: answer with nothing owed: status %0d key %h payload %h pos %0d count %0d",
                   $realtime, rsp_if.status, rsp_if.out_key, rsp_if.out_payload,
                   rsp_if.position, rsp_if.count);
        end
        answer_mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (rsp_if.status !== want.status || rsp_if.out_key !== want.out_key ||
            rsp_if.out_payload !== want.out_payload || rsp_if.position !== want.position ||
            rsp_if.count !== want.count) begin
          if (answer_mismatches < 10) begin
            $display("%0t: expected status %0d key %h payload %h pos %0d count %0d",
                     $realtime, want.status, want.out_key, want.out_payload,
                     want.position, want.count);
            $display("%0t: actual   status %0d key %h payload %h pos %0d count %0d",
                     $realtime, rsp_if.status, rsp_if.out_key, rsp_if.out_payload,
                     rsp_if.position, rsp_if.count);
          end
          answer_mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.func          = '0;
    req_if.entry_key     = '0;
    req_if.entry_payload = '0;
    cycle_cnt            = 0;
    answer_mismatches    = 0;
    shadow_head          = 0;
    shadow_held          = 0;
    shadow_cursor        = 0;
    sender_idle_en       = 1'b1;
    rx_idle_en           = 1'b1;
    rx_hold_req          = 0;
    key_pool[0]          = '0;
    key_pool[1]          = 32'hFFFF_FFFF;
    for (n = 2; n < KEY_POOL_N; n++) key_pool[n] = $urandom;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_fill_to_capacity();
    test_answer_backpressure();
    test_random_mix(880, 1'b1);
    // Last stretch runs flat out on both sides.
    test_random_mix(100, 1'b0);

    req_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 4) @(posedge clk_i);
    if (answer_mismatches == 0 && pending_answers.size() == 0) begin
      $display("circular_deque_with_key_search_tb: done, clean");
    end else begin
      $display("circular_deque_with_key_search_tb: done, errors");
    end
    $finish;
  end

endmodule
